/* rtl/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg
// shared constants and types of the 3x3 matrix inverse unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

  localparam int NUM_ELEM    = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

/* rtl/m3i_front.sv */
// ----------------------------------------------------------------------------
// m3i_front
// accepts matrices, forms the nine cofactors and the exact determinant
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3i_front #(
  parameter int W = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [m3i_pkg::NUM_ELEM*W-1:0]  a_bus,
  input  m3i_pkg::queue_stat_t            qstat,
  output logic                            push,
  output logic [m3i_pkg::NUM_ELEM*(2*W+1)+3*W+2:0] entry
);
  import m3i_pkg::*;

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int PW = 2 * W;

  logic [3:0] fv;
  logic       fe;

  logic signed [W-1:0]  el     [NUM_ELEM];
  logic signed [PW-1:0] p0     [NUM_ELEM];
  logic signed [PW-1:0] p1     [NUM_ELEM];
  logic signed [W-1:0]  r0_s1  [3];
  logic signed [W-1:0]  r0_s2  [3];
  logic signed [CW-1:0] cof_s2 [NUM_ELEM];
  logic signed [CW-1:0] cof_s3 [NUM_ELEM];
  logic signed [CW-1:0] cof_s4 [NUM_ELEM];
  logic signed [CW-1:0] pl     [3];
  logic signed [CW-1:0] ph     [3];
  logic signed [DW-1:0] det_s4;
  logic signed [DW-1:0] det_next;

  assign fe       = !fv[3] || !qstat.full;
  assign in_stall = !fe;
  assign push     = fv[3] && !qstat.full;

  genvar gi, gr, gc;
  generate
    for (gi = 0; gi < NUM_ELEM; gi++) begin : g_el
      assign el[gi] = a_bus[gi*W +: W];
      assign entry[gi*CW +: CW] = cof_s4[gi];
    end
  endgenerate
  assign entry[NUM_ELEM*CW +: DW] = det_s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (fe) begin
      fv <= {fv[2:0], in_valid};
    end
  end

  // products of the cofactor terms
  generate
    for (gr = 0; gr < 3; gr++) begin : g_r
      for (gc = 0; gc < 3; gc++) begin : g_c
        localparam int C1 = (gc + 1) % 3;
        localparam int C2 = (gc + 2) % 3;
        localparam int R1 = (gr + 1) % 3;
        localparam int R2 = (gr + 2) % 3;
        always_ff @(posedge clk) begin
          if (fe) begin
            p0[gr*3+gc]     <= el[C1*3+R1] * el[C2*3+R2];
            p1[gr*3+gc]     <= el[C1*3+R2] * el[C2*3+R1];
            cof_s2[gr*3+gc] <= CW'(p0[gr*3+gc]) - CW'(p1[gr*3+gc]);
            cof_s3[gr*3+gc] <= cof_s2[gr*3+gc];
            cof_s4[gr*3+gc] <= cof_s3[gr*3+gc];
          end
        end
      end
    end
  endgenerate

  // determinant partial products, cofactor split into low and high halves
  generate
    for (gc = 0; gc < 3; gc++) begin : g_det
      always_ff @(posedge clk) begin
        if (fe) begin
          r0_s1[gc] <= el[gc];
          r0_s2[gc] <= r0_s1[gc];
          pl[gc]    <= r0_s2[gc] * $signed({1'b0, cof_s2[gc*3][W-1:0]});
          ph[gc]    <= r0_s2[gc] * $signed(cof_s2[gc*3][CW-1:W]);
        end
      end
    end
  endgenerate

  always_comb begin
    det_next = (DW'(ph[0]) <<< W) + DW'(pl[0])
             + (DW'(ph[1]) <<< W) + DW'(pl[1])
             + (DW'(ph[2]) <<< W) + DW'(pl[2]);
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      det_s4 <= det_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/m3i_queue.sv */
// ----------------------------------------------------------------------------
// m3i_queue
// short queue between the cofactor front and the divider back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3i_queue #(
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [EW-1:0]        wr_data,
  input  logic                 pop,
  output logic [EW-1:0]        rd_data,
  output m3i_pkg::queue_stat_t qstat
);
  import m3i_pkg::*;

  logic [EW-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp;
  logic [QUEUE_AW-1:0] rp;
  logic [QUEUE_AW:0]   cnt;

  assign qstat.full  = cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign qstat.empty = cnt == '0;
  assign rd_data     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/m3i_div_lane.sv */
// ----------------------------------------------------------------------------
// m3i_div_lane
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3i_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [2*W:0]    cof,
  input  logic [3*W+2:0]         dmag,
  input  logic                   dneg,
  output logic [W-1:0]           q,
  output logic                   neg,
  output logic                   ovf
);
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * F;
  localparam int RW = (NW > DW + W) ? NW : DW + W;

  logic [NW-1:0] rem_s  [W+1];
  logic [W-1:0]  q_s    [W+1];
  logic [DW-1:0] dm_s   [W+1];
  logic          neg_s  [W+1];
  logic          ovf_s  [W+1];
  logic [RW-1:0] trial  [W];
  logic          ge     [W];

  logic [CW-1:0] cof_abs;
  logic [NW-1:0] nmag;

  assign cof_abs = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign nmag    = {cof_abs, {(2*F){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= nmag;
      q_s[0]   <= '0;
      dm_s[0]  <= dmag;
      neg_s[0] <= cof[CW-1] ^ dneg;
      ovf_s[0] <= RW'(nmag) >= (RW'(dmag) << W);
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < W; gk++) begin : g_st
      assign trial[gk] = RW'(dm_s[gk]) << (W - 1 - gk);
      assign ge[gk]    = RW'(rem_s[gk]) >= trial[gk];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[gk+1] <= ge[gk] ? rem_s[gk] - trial[gk][NW-1:0] : rem_s[gk];
          q_s[gk+1]   <= {q_s[gk][W-2:0], ge[gk]};
          dm_s[gk+1]  <= dm_s[gk];
          neg_s[gk+1] <= neg_s[gk];
          ovf_s[gk+1] <= ovf_s[gk];
        end
      end
    end
  endgenerate

  assign q   = q_s[W];
  assign neg = neg_s[W];
  assign ovf = ovf_s[W];

endmodule

`default_nettype wire

/* rtl/m3i_back.sv */
// ----------------------------------------------------------------------------
// m3i_back
// takes queued cofactors and determinant, divides and saturates, gives zero when singular
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3i_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [m3i_pkg::NUM_ELEM*(2*W+1)+3*W+2:0] entry,
  input  m3i_pkg::queue_stat_t                    qstat,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [m3i_pkg::NUM_ELEM*W-1:0]          b_bus,
  output logic                                    singular,
  output logic                                    saturated
);
  import m3i_pkg::*;

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic          be;
  logic [W+1:0]  v;
  logic [W+1:0]  z;

  logic signed [CW-1:0] cof_p [NUM_ELEM];
  logic [DW-1:0]        dmag_p;
  logic                 dneg_p;
  logic [DW-1:0]        det_in;

  logic [W-1:0] lq   [NUM_ELEM];
  logic         lneg [NUM_ELEM];
  logic         lovf [NUM_ELEM];
  logic [W-1:0] val  [NUM_ELEM];
  logic         lsat [NUM_ELEM];
  logic         any_sat;

  assign be     = !out_valid || !out_stall;
  assign pop    = be && !qstat.empty;
  assign det_in = entry[NUM_ELEM*CW +: DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (be) begin
      v         <= {v[W:0], !qstat.empty};
      out_valid <= v[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      dneg_p <= det_in[DW-1];
      dmag_p <= det_in[DW-1] ? DW'(-det_in) : det_in;
      z      <= {z[W:0], det_in == '0};
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_ELEM; gi++) begin : g_lane
      logic [W-1:0] lim;
      logic [W-1:0] qf;

      always_ff @(posedge clk) begin
        if (be) begin
          cof_p[gi] <= entry[gi*CW +: CW];
        end
      end

      m3i_div_lane #(.W(W), .F(F)) u_lane (
        .clk  (clk),
        .en   (be),
        .cof  (cof_p[gi]),
        .dmag (dmag_p),
        .dneg (dneg_p),
        .q    (lq[gi]),
        .neg  (lneg[gi]),
        .ovf  (lovf[gi])
      );

      always_comb begin
        lim      = lneg[gi] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        lsat[gi] = !z[W+1] && (lovf[gi] || (lq[gi] > lim));
        qf       = lsat[gi] ? lim : lq[gi];
        if (z[W+1]) begin
          val[gi] = '0;
        end else begin
          val[gi] = lneg[gi] ? W'(-qf) : qf;
        end
      end

      always_ff @(posedge clk) begin
        if (be) begin
          b_bus[gi*W +: W] <= val[gi];
        end
      end
    end
  endgenerate

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      any_sat = any_sat | lsat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      singular  <= z[W+1];
      saturated <= any_sat;
    end
  end

endmodule

`default_nettype wire

/* rtl/matrix3x3_inverse_unit.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// exact 3x3 fixed-point matrix inverse by adjugate and determinant
// ----------------------------------------------------------------------------
// throughput: one item per cycle while neither side stalls, set by the bit-per-stage divider pipeline
// front and back stall independently through a four-entry queue
// reset clears all valid and queue state, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module matrix3x3_inverse_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] a_r0c0,
  input  logic signed [DATA_WIDTH-1:0] a_r0c1,
  input  logic signed [DATA_WIDTH-1:0] a_r0c2,
  input  logic signed [DATA_WIDTH-1:0] a_r1c0,
  input  logic signed [DATA_WIDTH-1:0] a_r1c1,
  input  logic signed [DATA_WIDTH-1:0] a_r1c2,
  input  logic signed [DATA_WIDTH-1:0] a_r2c0,
  input  logic signed [DATA_WIDTH-1:0] a_r2c1,
  input  logic signed [DATA_WIDTH-1:0] a_r2c2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] b_r0c0,
  output logic signed [DATA_WIDTH-1:0] b_r0c1,
  output logic signed [DATA_WIDTH-1:0] b_r0c2,
  output logic signed [DATA_WIDTH-1:0] b_r1c0,
  output logic signed [DATA_WIDTH-1:0] b_r1c1,
  output logic signed [DATA_WIDTH-1:0] b_r1c2,
  output logic signed [DATA_WIDTH-1:0] b_r2c0,
  output logic signed [DATA_WIDTH-1:0] b_r2c1,
  output logic signed [DATA_WIDTH-1:0] b_r2c2,
  output logic                         singular,
  output logic                         saturated
);
  import m3i_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int EW = NUM_ELEM * (2 * W + 1) + 3 * W + 3;

  logic [NUM_ELEM*W-1:0] a_bus;
  logic [NUM_ELEM*W-1:0] b_bus;
  logic [EW-1:0]         wr_entry;
  logic [EW-1:0]         rd_entry;
  logic                  push;
  logic                  pop;
  queue_stat_t           qstat;

  assign a_bus = {a_r2c2, a_r2c1, a_r2c0, a_r1c2, a_r1c1, a_r1c0, a_r0c2, a_r0c1, a_r0c0};
  assign {b_r2c2, b_r2c1, b_r2c0, b_r1c2, b_r1c1, b_r1c0, b_r0c2, b_r0c1, b_r0c0} = b_bus;

  m3i_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .a_bus    (a_bus),
    .qstat    (qstat),
    .push     (push),
    .entry    (wr_entry)
  );

  m3i_queue #(.EW(EW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .qstat   (qstat)
  );

  m3i_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (rd_entry),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .b_bus     (b_bus),
    .singular  (singular),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks the 3x3 fixed-point matrix inverse unit against an exact predictor:
// directed matrices cover extremes, singular and saturating cases; random
// matrices stream in, first with random idle and stall bursts on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [DW-1:0] elem_t;

  typedef struct {
    elem_t b [9];
    logic  sing;
    logic  sat;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  elem_t a [9];
  logic out_valid;
  logic out_stall = 1'b0;
  elem_t b [9];
  logic singular, saturated;

  inverse_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  initial for (int i = 0; i < 9; i++) a[i] = '0;

  matrix3x3_inverse_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .a_r0c0(a[0]), .a_r0c1(a[1]), .a_r0c2(a[2]),
    .a_r1c0(a[3]), .a_r1c1(a[4]), .a_r1c2(a[5]),
    .a_r2c0(a[6]), .a_r2c1(a[7]), .a_r2c2(a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .b_r0c0(b[0]), .b_r0c1(b[1]), .b_r0c2(b[2]),
    .b_r1c0(b[3]), .b_r1c1(b[4]), .b_r1c2(b[5]),
    .b_r2c0(b[6]), .b_r2c1(b[7]), .b_r2c2(b[8]),
    .singular(singular), .saturated(saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // exact adjugate over determinant, truncated toward zero, saturated
  function automatic inverse_t invert(elem_t m [9]);
    inverse_t res;
    logic signed [255:0] e [3][3];
    logic signed [255:0] cof [3][3];
    logic signed [255:0] det, dmag, num, q;
    logic signed [255:0] hi, lo;
    hi = (256'sd1 <<< (DW - 1)) - 1;
    lo = -(256'sd1 <<< (DW - 1));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r][c] = m[r*3+c];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = e[(c+1)%3][(r+1)%3] * e[(c+2)%3][(r+2)%3]
                  - e[(c+1)%3][(r+2)%3] * e[(c+2)%3][(r+1)%3];
    det = e[0][0]*cof[0][0] + e[0][1]*cof[1][0] + e[0][2]*cof[2][0];
    res.sing = (det == 0);
    res.sat = 1'b0;
    for (int i = 0; i < 9; i++) res.b[i] = '0;
    if (!res.sing) begin
      dmag = (det < 0) ? -det : det;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          num = cof[r][c] <<< (2*FB);
          q = ((num < 0) ? -num : num) / dmag;
          if ((num < 0) != (det < 0)) q = -q;
          if (q > hi) begin
            q = hi;
            res.sat = 1'b1;
          end else if (q < lo) begin
            q = lo;
            res.sat = 1'b1;
          end
          res.b[r*3+c] = q[DW-1:0];
        end
    end
    return res;
  endfunction

  task automatic report(string what, int idx, logic [DW-1:0] got, logic [DW-1:0] want);
    errors++;
    $display("mismatch %s[%0d]: got %h want %h", what, idx, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", 0, 0, 0);
      end else begin
        inverse_t w;
        w = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (b[i] !== w.b[i]) report("b", i, b[i], w.b[i]);
        if (singular !== w.sing) report("singular", 0, singular, w.sing);
        if (saturated !== w.sat) report("saturated", 0, saturated, w.sat);
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_matrix(elem_t m [9]);
    int n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) a[i] <= m[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(invert(m));
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return elem_t'($signed($urandom_range(0, 8*65536)) - 4*65536);
      3: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return elem_t'($signed($urandom_range(0, 512*65536)) - 256*65536);
    endcase
  endfunction

  task automatic test_identity_and_scaled();
    elem_t m [9];
    int s [5] = '{65536, 1, -65536, 2*65536, 32768};
    foreach (s[k]) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? s[k] : 0;
      send_matrix(m);
    end
  endtask

  task automatic test_singular();
    elem_t m [9];
    for (int i = 0; i < 9; i++) m[i] = '0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = i * 65536;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i < 3) ? 32'sh7fffffff : 32'sh7fffffff;
    send_matrix(m);
  endtask

  task automatic test_extremes();
    elem_t m [9];
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'sh80000000 : 0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'sh7fffffff : 0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? -1 : 0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'sh80000000 : 32'sh7fffffff;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
    m[4] = 1;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = '1;
    m[0] = 0;
    m[4] = 0;
    m[8] = 0;
    send_matrix(m);
    // negative determinant with truncation of inexact quotients
    m = '{3, 1, 0, 1, 2, 0, 0, 0, -7};
    send_matrix(m);
    m = '{-3*65536, 1, 5, 7, 2*65536, -1, 0, 9, 65536};
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    elem_t m [9];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      if ($urandom_range(0, 19) == 0) m[6 + $urandom_range(0, 2)] = 0;
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) m[6+i] = m[3+i];
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_and_scaled();
    test_singular();
    test_extremes();
    test_random(800);
    idle_on = 1'b0;
    test_random(150);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DW + 16) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
